### rtl/bfk_pkg.sv
// ----------------------------------------------------------------------------
// bfk_pkg
// Shared constants, codes and helpers for the cipher engine.
// ----------------------------------------------------------------------------
package bfk_pkg;

  localparam int unsigned TABLE_WORDS = 1042;
  localparam int unsigned ADDR_W      = 11;
  localparam int unsigned P_LAST      = 17;

  localparam logic [ADDR_W-1:0] SBOX0     = 11'h012;
  localparam logic [ADDR_W-1:0] SBOX1     = 11'h112;
  localparam logic [ADDR_W-1:0] SBOX2     = 11'h212;
  localparam logic [ADDR_W-1:0] SBOX3     = 11'h312;
  localparam logic [ADDR_W-1:0] LAST_PAIR = 11'h410;
  localparam logic [ADDR_W-1:0] WORD_END  = 11'h412;
  localparam logic [ADDR_W-1:0] ENC_W0    = 11'h010;
  localparam logic [ADDR_W-1:0] ENC_W1    = 11'h011;
  localparam logic [ADDR_W-1:0] DEC_W0    = 11'h001;
  localparam logic [ADDR_W-1:0] DEC_W1    = 11'h000;

  typedef enum logic [1:0] {
    FN_LOAD = 2'd0,
    FN_KEY  = 2'd1,
    FN_ENC  = 2'd2,
    FN_DEC  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_E1   = 2'd0,
    PH_E2   = 2'd1,
    PH_FILL = 2'd2,
    PH_BLK  = 2'd3
  } phase_t;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_P    = 14'b00000000000010,
    ST_Z    = 14'b00000000000100,
    ST_F0   = 14'b00000000001000,
    ST_F1   = 14'b00000000010000,
    ST_F2   = 14'b00000000100000,
    ST_F3   = 14'b00000001000000,
    ST_W1   = 14'b00000010000000,
    ST_W2   = 14'b00000100000000,
    ST_NXT  = 14'b00001000000000,
    ST_XR   = 14'b00010000000000,
    ST_XW   = 14'b00100000000000,
    ST_FH   = 14'b01000000000000,
    ST_FL   = 14'b10000000000000
  } state_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### rtl/blowfish_key1_engine.sv
// ----------------------------------------------------------------------------
// blowfish_key1_engine
// Iterative 64-bit Feistel cipher with a loadable 1042-word P/S table and
// an in-place key schedule that rebuilds the table.
// ----------------------------------------------------------------------------
//   channel   | handshake           | payload
//   command   | start / busy        | func, table_index, table_word, id_code,
//             |                     | key_level, block_in
//   result    | done (1-cycle beat) | block_out
//
// One table port: every round reads P then four S-box words in turn.
// A load beat writes in its own cycle; busy stays low.
// A key beat runs each pass as 2 + 521 block passes, an XOR update of the
// 18 P words and 1042 table writes.
// Reset returns the sequencer to idle; the table keeps its contents.
// done is a single-cycle beat; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module blowfish_key1_engine
  import bfk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [10:0] table_index,
  input  logic [31:0] table_word,
  input  logic [31:0] id_code,
  input  logic [1:0]  key_level,
  input  logic [63:0] block_in,
  output logic        done,
  output logic [63:0] block_out
);

  logic [31:0] tbl [TABLE_WORDS];

  state_t      state;
  phase_t      phase;
  logic        dec;
  logic [3:0]  rnd;
  logic [1:0]  level;
  logic [1:0]  pass;
  logic [10:0] idx;
  logic [31:0] yv, xv, zr, f, kw0, kw1, kw2;
  logic [31:0] rdata;

  logic [10:0] raddr;
  logic        we;
  logic [10:0] waddr;
  logic [31:0] wdata;
  logic [31:0] z;
  logic [31:0] fsum;
  logic [3:0]  rnd_next;
  logic [1:0]  pass_next;

  assign busy      = (state != ST_IDLE);
  assign z         = rdata ^ xv;
  assign fsum      = rdata + f;
  assign rnd_next  = rnd + 4'd1;
  assign pass_next = pass + 2'd1;

  function automatic logic [10:0] p_addr(input logic d, input logic [3:0] r);
    return d ? (11'(P_LAST) - {7'd0, r}) : {7'd0, r};
  endfunction

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      ST_P:  raddr = p_addr(dec, rnd);
      ST_Z:  raddr = SBOX0 + {3'd0, z[31:24]};
      ST_F0: raddr = SBOX1 + {3'd0, zr[23:16]};
      ST_F1: raddr = SBOX2 + {3'd0, zr[15:8]};
      ST_F2: raddr = SBOX3 + {3'd0, zr[7:0]};
      ST_F3: raddr = (rnd == 4'd15) ? (dec ? DEC_W0 : ENC_W0) : p_addr(dec, rnd_next);
      ST_W1: raddr = dec ? DEC_W1 : ENC_W1;
      ST_XR: raddr = idx;
      ST_XW: begin
        we    = 1'b1;
        waddr = idx;
        wdata = rdata ^ swap_bytes(idx[0] ? kw1 : kw0);
      end
      ST_FH: begin
        we    = 1'b1;
        waddr = idx;
        wdata = yv;
      end
      ST_FL: begin
        we    = 1'b1;
        waddr = idx + 11'd1;
        wdata = xv;
      end
      ST_IDLE: begin
        we    = !rst && start && (func == FN_LOAD) && (table_index < WORD_END);
        waddr = table_index;
        wdata = table_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tbl[waddr] <= wdata;
    end
    rdata <= tbl[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            rnd <= '0;
            case (func_t'(func))
              FN_KEY: begin
                kw0   <= id_code;
                kw1   <= id_code >> 1;
                kw2   <= id_code << 1;
                yv    <= id_code >> 1;
                xv    <= id_code << 1;
                dec   <= 1'b0;
                level <= key_level;
                pass  <= '0;
                phase <= PH_E1;
                if (key_level != 2'd0) begin
                  state <= ST_P;
                end
              end
              FN_ENC, FN_DEC: begin
                yv    <= block_in[31:0];
                xv    <= block_in[63:32];
                dec   <= (func == FN_DEC);
                phase <= PH_BLK;
                state <= ST_P;
              end
              default: ;
            endcase
          end
        end
        ST_P: state <= ST_Z;
        ST_Z: begin
          zr    <= z;
          state <= ST_F0;
        end
        ST_F0: begin
          f     <= rdata;
          state <= ST_F1;
        end
        ST_F1: begin
          f     <= fsum;
          state <= ST_F2;
        end
        ST_F2: begin
          f     <= rdata ^ f;
          state <= ST_F3;
        end
        ST_F3: begin
          xv <= fsum ^ yv;
          yv <= zr;
          if (rnd == 4'd15) begin
            state <= ST_W1;
          end else begin
            rnd   <= rnd_next;
            state <= ST_Z;
          end
        end
        ST_W1: begin
          xv    <= xv ^ rdata;
          state <= ST_W2;
        end
        ST_W2: begin
          yv    <= yv ^ rdata;
          state <= ST_NXT;
        end
        ST_NXT: begin
          rnd <= '0;
          case (phase)
            PH_BLK: begin
              block_out <= {yv, xv};
              done      <= 1'b1;
              state     <= ST_IDLE;
            end
            PH_E1: begin
              kw1   <= xv;
              kw2   <= yv;
              yv    <= kw0;
              phase <= PH_E2;
              state <= ST_P;
            end
            PH_E2: begin
              kw0   <= xv;
              kw1   <= yv;
              idx   <= '0;
              state <= ST_XR;
            end
            default: state <= ST_FH;
          endcase
        end
        ST_XR: state <= ST_XW;
        ST_XW: begin
          if (idx == 11'(P_LAST)) begin
            idx   <= '0;
            yv    <= '0;
            xv    <= '0;
            phase <= PH_FILL;
            state <= ST_P;
          end else begin
            idx   <= idx + 11'd1;
            state <= ST_XR;
          end
        end
        ST_FH: state <= ST_FL;
        ST_FL: begin
          if (idx == LAST_PAIR) begin
            pass <= pass_next;
            if (pass_next == level) begin
              state <= ST_IDLE;
            end else begin
              phase <= PH_E1;
              state <= ST_P;
              if (pass_next == 2'd2) begin
                kw1 <= kw1 << 1;
                kw2 <= kw2 >> 1;
                yv  <= kw1 << 1;
                xv  <= kw2 >> 1;
              end else begin
                yv <= kw1;
                xv <= kw2;
              end
            end
          end else begin
            idx   <= idx + 11'd2;
            yv    <= xv;
            xv    <= yv;
            state <= ST_P;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
